[hdl/diffusion_ftcs_stencil_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the diffusion stencil checker
// Clocked concurrent assertions with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef DIFFUSION_FTCS_STENCIL_MACROS_SVH
`define DIFFUSION_FTCS_STENCIL_MACROS_SVH

// checked only while reset is released
`define DFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset too
`define DFS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/dfs_pkg.sv]
// ----------------------------------------------------------------------------
// dfs_pkg
// Types, codes and saturation helper for the 2-D FTCS diffusion stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

  localparam int SIDE_W = 7;
  localparam int IDX_W  = 12;
  localparam int CFG_IW = 3;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [CFG_IW-1:0] REG_SIDE  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_STEPS = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DT    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_AXX   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_AYY   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_REACT = 3'd5;

  localparam logic [SIDE_W-1:0] RST_SIDE  = 7'd10;
  localparam logic [15:0]       RST_STEPS = 16'd100;
  localparam logic [30:0]       RST_DT    = 31'd13107;
  localparam logic [31:0]       RST_AXX   = 32'd65536;
  localparam logic [31:0]       RST_AYY   = 32'd65536;
  localparam logic [31:0]       RST_REACT = 32'd0;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [IDX_W-1:0]  cell_index;
    logic signed [31:0] cell_value;
    logic signed [31:0] source_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [15:0]        steps_done;
    logic               index_error;
  } out_t;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/diffusion_ftcs_stencil.sv]
// ----------------------------------------------------------------------------
// diffusion_ftcs_stencil
// 2-D explicit diffusion on a square grid, 5-point stencil, Q16.16 saturating.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake        Beat
// in       in   valid / stall    in_t: opcode, cell_index, cell_value, source_value
// out      out  valid / stall    out_t: read_value, steps_done, index_error
// cfg      in   valid / ready    register index, 32-bit data
//
// Load writes the grids directly. Read goes through a registered grid memory read.
// Run: a setup sequence, then per step the stencil sequence for each interior cell
// over the single grid read port and shared multiplier, followed by the copy-back
// of every interior cell, and finally the delivery of the beat.
// Reset clears control and sets config to its defaults; the grids hold nothing until loaded.
// Input stalls while an item is in work or the output beat is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module diffusion_ftcs_stencil import dfs_pkg::*; #(
  parameter int MAX_SIDE  = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_t               in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_t                   out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CFG_IW-1:0] cfg_index_i,
  input  wire logic [31:0]       cfg_data_i
);

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int XW    = (SW > SIDE_W) ? SW : SIDE_W;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = 2 * SW;
  localparam int IW    = (NW > IDX_W) ? NW : IDX_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_RDWAIT = 6'b000010,
    ST_SETUP  = 6'b000100,
    ST_CELL   = 6'b001000,
    ST_COPY   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  localparam logic [3:0] PH_RD_U   = 4'd0;
  localparam logic [3:0] PH_RD_E   = 4'd1;
  localparam logic [3:0] PH_RD_W   = 4'd2;
  localparam logic [3:0] PH_RD_N   = 4'd3;
  localparam logic [3:0] PH_RD_S   = 4'd4;
  localparam logic [3:0] PH_AX     = 4'd5;
  localparam logic [3:0] PH_DY     = 4'd6;
  localparam logic [3:0] PH_AY     = 4'd7;
  localparam logic [3:0] PH_AXGET  = 4'd8;
  localparam logic [3:0] PH_LAP    = 4'd10;
  localparam logic [3:0] PH_DIF    = 4'd13;
  localparam logic [3:0] PH_WR     = 4'd14;
  localparam logic [3:0] PH_SC_GET = 4'd2;
  localparam logic [3:0] PH_CD_GET = 4'd4;

  state_e              st_q;
  logic [3:0]          ph_q;
  logic [AW-1:0]       k_q;
  logic [SW-1:0]       i_q, j_q;
  logic [15:0]         step_q;
  logic                out_vld_q;
  out_t                out_q;

  logic [SIDE_W-1:0]   side_q;
  logic [15:0]         steps_q;
  logic [30:0]         dt_q;
  logic signed [31:0]  axx_q, ayy_q, rc_q;

  logic signed [31:0]  u_q, s_q, d_q, cdt_q;
  logic signed [32:0]  h_q, v_q;
  logic signed [33:0]  acc_q;
  logic [30:0]         scale_q;

  logic signed [31:0]  cur_mem [DEPTH];
  logic signed [31:0]  nxt_mem [DEPTH];
  logic signed [31:0]  src_mem [DEPTH];
  logic signed [31:0]  cur_rd_q, nxt_rd_q, src_rd_q;

  logic [XW-1:0]       side_x;
  logic [SW-1:0]       n_w, nm2_w;
  logic [NW-1:0]       nn_w, nm1sq_w;
  logic                idx_bad, accept, last_cell;
  logic [AW-1:0]       idx_a, k_start, k_step;
  logic [AW-1:0]       cur_ra, cur_wa;
  logic signed [31:0]  cur_wd;
  logic                cur_we, src_we, nxt_we;
  logic signed [32:0]  op_a, op_b;
  logic signed [65:0]  prod_w;
  logic signed [31:0]  fix_w;

  assign side_x  = XW'(side_q);
  assign n_w     = (side_x > XW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(side_x);
  assign nm2_w   = n_w - SW'(2);
  assign nn_w    = NW'(n_w) * NW'(n_w);
  assign nm1sq_w = NW'(n_w - SW'(1)) * NW'(n_w - SW'(1));
  assign idx_bad = IW'(in_data_i.cell_index) >= IW'(nn_w);
  assign idx_a   = AW'(in_data_i.cell_index);
  assign k_start = AW'(n_w) + AW'(1);
  assign k_step  = (j_q == nm2_w) ? AW'(3) : AW'(1);
  assign last_cell = (i_q == nm2_w) && (j_q == nm2_w);

  assign in_stall_o  = (st_q != ST_IDLE) || (out_vld_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    cur_ra = k_q;
    if (st_q == ST_IDLE) begin
      cur_ra = idx_a;
    end else if (st_q == ST_CELL) begin
      case (ph_q)
        PH_RD_U: cur_ra = k_q;
        PH_RD_E: cur_ra = k_q + AW'(1);
        PH_RD_W: cur_ra = k_q - AW'(1);
        PH_RD_N: cur_ra = k_q + AW'(n_w);
        PH_RD_S: cur_ra = k_q - AW'(n_w);
        default: cur_ra = k_q;
      endcase
    end
  end

  always_comb begin
    cur_we = 1'b0;
    cur_wa = idx_a;
    cur_wd = in_data_i.cell_value;
    if (accept && in_data_i.opcode == OP_LOAD && !idx_bad) begin
      cur_we = 1'b1;
    end else if (st_q == ST_COPY && ph_q == PH_RD_E) begin
      cur_we = 1'b1;
      cur_wa = k_q;
      cur_wd = nxt_rd_q;
    end
  end

  assign src_we = accept && in_data_i.opcode == OP_LOAD && !idx_bad;
  assign nxt_we = (st_q == ST_CELL) && (ph_q == PH_WR);

  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[cur_wa] <= cur_wd;
    end
    cur_rd_q <= cur_mem[cur_ra];
  end

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[idx_a] <= in_data_i.source_value;
    end
    src_rd_q <= src_mem[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[k_q] <= sat34(acc_q);
    end
    nxt_rd_q <= nxt_mem[k_q];
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (st_q == ST_SETUP) begin
      if (ph_q == PH_RD_U) begin
        op_a = {2'b00, dt_q};
        op_b = 33'(nm1sq_w);
      end else if (ph_q == PH_RD_E) begin
        op_a = {rc_q[31], rc_q};
        op_b = {2'b00, dt_q};
      end
    end else if (st_q == ST_CELL) begin
      case (ph_q)
        PH_RD_W: begin
          op_a = {2'b00, dt_q};
          op_b = {s_q[31], s_q};
        end
        PH_RD_N: begin
          op_a = {cdt_q[31], cdt_q};
          op_b = {u_q[31], u_q};
        end
        PH_AX: begin
          op_a = {axx_q[31], axx_q};
          op_b = {d_q[31], d_q};
        end
        PH_AY: begin
          op_a = {ayy_q[31], ayy_q};
          op_b = {d_q[31], d_q};
        end
        PH_LAP: begin
          op_a = {2'b00, scale_q};
          op_b = 33'(sat34({h_q[32], h_q} + {{2{fix_w[31]}}, fix_w}));
        end
        default: begin
          op_a = '0;
          op_b = '0;
        end
      endcase
    end
  end

  dfs_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .prod_o(prod_w),
    .fix_o (fix_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      ph_q      <= '0;
      k_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      step_q    <= '0;
      out_vld_q <= 1'b0;
      side_q    <= RST_SIDE;
      steps_q   <= RST_STEPS;
      dt_q      <= RST_DT;
      axx_q     <= RST_AXX;
      ayy_q     <= RST_AYY;
      rc_q      <= RST_REACT;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_SIDE:  side_q  <= cfg_data_i[SIDE_W-1:0];
          REG_STEPS: steps_q <= cfg_data_i[15:0];
          REG_DT:    dt_q    <= cfg_data_i[30:0];
          REG_AXX:   axx_q   <= cfg_data_i;
          REG_AYY:   ayy_q   <= cfg_data_i;
          REG_REACT: rc_q    <= cfg_data_i;
          default:   ;
        endcase
      end
      if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          ph_q <= '0;
          if (accept) begin
            if (in_data_i.opcode == OP_READ && !idx_bad) begin
              st_q <= ST_RDWAIT;
            end else if (in_data_i.opcode == OP_RUN) begin
              st_q <= (n_w < SW'(3) || steps_q == '0) ? ST_DONE : ST_SETUP;
            end else begin
              out_vld_q <= 1'b1;
            end
          end
        end
        ST_RDWAIT: begin
          out_vld_q <= 1'b1;
          st_q      <= ST_IDLE;
        end
        ST_SETUP: begin
          ph_q <= ph_q + 4'd1;
          if (ph_q == PH_CD_GET) begin
            st_q   <= ST_CELL;
            ph_q   <= '0;
            k_q    <= k_start;
            i_q    <= SW'(1);
            j_q    <= SW'(1);
            step_q <= '0;
          end
        end
        ST_CELL: begin
          ph_q <= ph_q + 4'd1;
          if (ph_q == PH_WR) begin
            ph_q <= '0;
            if (last_cell) begin
              st_q <= ST_COPY;
              k_q  <= k_start;
              i_q  <= SW'(1);
              j_q  <= SW'(1);
            end else begin
              k_q <= k_q + k_step;
              if (j_q == nm2_w) begin
                j_q <= SW'(1);
                i_q <= i_q + SW'(1);
              end else begin
                j_q <= j_q + SW'(1);
              end
            end
          end
        end
        ST_COPY: begin
          ph_q <= ph_q + 4'd1;
          if (ph_q == PH_RD_E) begin
            ph_q <= '0;
            if (last_cell) begin
              k_q    <= k_start;
              i_q    <= SW'(1);
              j_q    <= SW'(1);
              step_q <= step_q + 16'd1;
              st_q   <= (step_q + 16'd1 == steps_q) ? ST_DONE : ST_CELL;
            end else begin
              k_q <= k_q + k_step;
              if (j_q == nm2_w) begin
                j_q <= SW'(1);
                i_q <= i_q + SW'(1);
              end else begin
                j_q <= j_q + SW'(1);
              end
            end
          end
        end
        ST_DONE: begin
          out_vld_q <= 1'b1;
          st_q      <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          out_q.read_value  <= '0;
          out_q.steps_done  <= '0;
          out_q.index_error <= (in_data_i.opcode == OP_LOAD || in_data_i.opcode == OP_READ)
                               && idx_bad;
        end
      end
      ST_RDWAIT: out_q.read_value <= cur_rd_q;
      ST_DONE:   out_q.steps_done <= steps_q;
      ST_SETUP: begin
        if (ph_q == PH_SC_GET) begin
          scale_q <= (|prod_w[65:31]) ? 31'h7FFFFFFF : prod_w[30:0];
        end
        if (ph_q == PH_CD_GET) begin
          cdt_q <= fix_w;
        end
      end
      ST_CELL: begin
        case (ph_q)
          PH_RD_E: begin
            u_q <= cur_rd_q;
            s_q <= src_rd_q;
          end
          PH_RD_W: h_q <= {cur_rd_q[31], cur_rd_q};
          PH_RD_N: h_q <= h_q + {cur_rd_q[31], cur_rd_q};
          PH_RD_S: begin
            d_q <= sat34({h_q[32], h_q} - {u_q[31], u_q, 1'b0});
            v_q <= {cur_rd_q[31], cur_rd_q};
          end
          PH_AX: begin
            v_q   <= v_q + {cur_rd_q[31], cur_rd_q};
            acc_q <= {{2{u_q[31]}}, u_q} + {{2{fix_w[31]}}, fix_w};
          end
          PH_DY: begin
            d_q   <= sat34({v_q[32], v_q} - {u_q[31], u_q, 1'b0});
            acc_q <= acc_q + {{2{fix_w[31]}}, fix_w};
          end
          PH_AXGET: h_q <= {fix_w[31], fix_w};
          PH_DIF:   acc_q <= acc_q + {{2{fix_w[31]}}, fix_w};
          default:  ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hdl/dfs_mul.sv]
// ----------------------------------------------------------------------------
// dfs_mul
// Shared signed multiplier: registered operands, raw product, and the
// product shifted down by the fraction bits and clamped to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_mul import dfs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [65:0]      prod_o,
  output logic signed [31:0]      fix_o
);

  logic signed [32:0] a_q, b_q;
  logic signed [65:0] pr_q;
  logic signed [65:0] sh_w;
  logic signed [31:0] fx_q;

  assign sh_w = pr_q >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    a_q  <= a_i;
    b_q  <= b_i;
    pr_q <= a_q * b_q;
    if (sh_w > 66'sd2147483647) begin
      fx_q <= 32'sh7FFFFFFF;
    end else if (sh_w < -66'sd2147483648) begin
      fx_q <= 32'sh80000000;
    end else begin
      fx_q <= sh_w[31:0];
    end
  end

  assign prod_o = pr_q;
  assign fix_o  = fx_q;

endmodule

`default_nettype wire

[hdl/dfs_checker.sv]
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks on the diffusion stencil, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "diffusion_ftcs_stencil_macros.svh"

module dfs_checker import dfs_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire in_t               in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire out_t              out_data_o,
  input wire logic              cfg_valid_i,
  input wire logic              cfg_ready_o,
  input wire logic [CFG_IW-1:0] cfg_index_i,
  input wire logic [31:0]       cfg_data_i
);

  `DFS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "out beat dropped")
  `DFS_ASSERT(a_run_busy, in_valid_i && !in_stall_o && in_data_i.opcode == OP_RUN |=> in_stall_o, "run not held")
  `DFS_ASSERT(a_err_zero, out_valid_o && out_data_o.index_error |-> out_data_o.read_value == 0 && out_data_o.steps_done == 0, "error beat carries data")
  `DFS_ASSERT_RST(a_rst_quiet, !rst_ni |=> !out_valid_o, "out valid in reset")

endmodule

bind diffusion_ftcs_stencil dfs_checker u_dfs_checker (.*);

`default_nettype wire

[tb/tb_diffusion_ftcs_stencil.sv]
// ----------------------------------------------------------------------------
// tb_diffusion_ftcs_stencil
// Self-checking bench for the FTCS diffusion stencil: a directed table at
// reset settings, then random load/read/run traffic over several register
// settings, checked beat by beat against a behavioral model of the solver.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_diffusion_ftcs_stencil;
  import dfs_pkg::*;

  localparam int CELLS = 4096;
  localparam int LIMIT = 4000000;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct {
    in_t  beat;
    bit   typed;
    out_t res;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_t  in_data;
  out_t out_data;
  logic [CFG_IW-1:0] cfg_index;
  logic [31:0] cfg_data;

  // solver state
  logic signed [31:0] grid_cur [CELLS];
  logic signed [31:0] grid_nxt [CELLS];
  logic signed [31:0] grid_src [CELLS];
  bit loaded [CELLS];
  int loaded_upto;
  logic [6:0]  side_r;
  logic [15:0] steps_r;
  logic [30:0] dt_r;
  logic [31:0] axx_r, ayy_r, react_r;

  out_t pending[$];
  row_t plan[$];
  int errors = 0;
  int cycles = 0;
  int hold_req = 0;
  bit calm;

  diffusion_ftcs_stencil i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint frac_floor(longint v);
    return v >>> 16;
  endfunction

  function automatic int side_eff();
    return (side_r > 64) ? 64 : int'(side_r);
  endfunction

  function automatic void diffuse(int n);
    longint sc, scale, cdt, dt, axx, ayy, u, dx, dy, ax, ay, lap, dif, srt, rea;
    int k;
    if (n < 3) return;
    dt = longint'(dt_r);
    axx = longint'($signed(axx_r));
    ayy = longint'($signed(ayy_r));
    sc = dt * (n - 1) * (n - 1);
    scale = (sc > 64'sd2147483647) ? 64'sd2147483647 : sc;
    cdt = clamp32(frac_floor(longint'($signed(react_r)) * dt));
    for (int s = 0; s < int'(steps_r); s++) begin
      for (int i = 1; i < n - 1; i++) begin
        for (int j = 1; j < n - 1; j++) begin
          k = i * n + j;
          u = grid_cur[k];
          dx = clamp32(longint'(grid_cur[k+1]) + grid_cur[k-1] - 2 * u);
          dy = clamp32(longint'(grid_cur[k+n]) + grid_cur[k-n] - 2 * u);
          ax = clamp32(frac_floor(axx * dx));
          ay = clamp32(frac_floor(ayy * dy));
          lap = clamp32(ax + ay);
          dif = clamp32(frac_floor(scale * lap));
          srt = clamp32(frac_floor(dt * longint'(grid_src[k])));
          rea = clamp32(frac_floor(cdt * u));
          grid_nxt[k] = 32'(clamp32(u + dif + srt + rea));
        end
      end
      for (int i = 1; i < n - 1; i++)
        for (int j = 1; j < n - 1; j++) grid_cur[i*n+j] = grid_nxt[i*n+j];
    end
  endfunction

  function automatic out_t solve_beat(in_t it);
    out_t r;
    int n;
    bit bad;
    r = '0;
    n = side_eff();
    bad = int'(it.cell_index) >= n * n;
    case (it.opcode)
      OP_LOAD: begin
        if (bad) begin
          r.index_error = 1'b1;
        end else begin
          grid_cur[it.cell_index] = it.cell_value;
          grid_src[it.cell_index] = it.source_value;
          loaded[it.cell_index] = 1'b1;
          while (loaded_upto < CELLS && loaded[loaded_upto]) loaded_upto++;
        end
      end
      OP_RUN: begin
        diffuse(n);
        r.steps_done = steps_r;
      end
      OP_READ: begin
        if (bad) r.index_error = 1'b1;
        else r.read_value = grid_cur[it.cell_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  // output checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %h", out_data);
      end else begin
        if (out_data.read_value !== pending[0].read_value ||
            out_data.steps_done !== pending[0].steps_done ||
            out_data.index_error !== pending[0].index_error) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp val=%h steps=%0d err=%b got val=%h steps=%0d err=%b",
                     pending[0].read_value, pending[0].steps_done, pending[0].index_error,
                     out_data.read_value, out_data.steps_done, out_data.index_error);
        end
        void'(pending.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    int hold_seen;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_stall <= 1'b1;
        for (int c = 0; c < 400; c++) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic send_beat(in_t it, bit typed, out_t res);
    out_t p;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    p = solve_beat(it);
    pending.insert(pending.size(), typed ? res : p);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic send_row(row_t r);
    send_beat(r.beat, r.typed, r.res);
  endtask

  task automatic send_op(logic [1:0] op, int idx, logic [31:0] v, logic [31:0] s);
    in_t it;
    it.opcode = op;
    it.cell_index = 12'(idx);
    it.cell_value = v;
    it.source_value = s;
    send_beat(it, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_put(logic [CFG_IW-1:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      REG_SIDE:  side_r  = d[6:0];
      REG_STEPS: steps_r = d[15:0];
      REG_DT:    dt_r    = d[30:0];
      REG_AXX:   axx_r   = d;
      REG_AYY:   ayy_r   = d;
      REG_REACT: react_r = d;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] sd, logic [31:0] st, logic [31:0] dt,
                          logic [31:0] ax, logic [31:0] ay, logic [31:0] rc);
    cfg_put(REG_SIDE, sd);
    cfg_put(REG_STEPS, st);
    cfg_put(REG_DT, dt);
    cfg_put(REG_AXX, ax);
    cfg_put(REG_AYY, ay);
    cfg_put(REG_REACT, rc);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] cell_rand();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  function automatic row_t row(logic [1:0] op, int idx, logic [31:0] v, logic [31:0] s,
                               bit typed, logic [31:0] rv, logic [15:0] sd, bit er);
    row_t r;
    r.beat.opcode = op;
    r.beat.cell_index = 12'(idx);
    r.beat.cell_value = v;
    r.beat.source_value = s;
    r.typed = typed;
    r.res.read_value = rv;
    r.res.steps_done = sd;
    r.res.index_error = er;
    return r;
  endfunction

  task automatic random_phase(int count, bit hold_once, bit pause_once);
    int n, area, idx, pick;
    n = side_eff();
    area = n * n;
    if (n <= 8)
      for (int k = loaded_upto; k < area; k++) send_op(OP_LOAD, k, cell_rand(), cell_rand());
    for (int c = 0; c < count; c++) begin
      if (hold_once && c == count / 3) hold_req++;
      if (pause_once && c == count / 2) drain();
      if (c == count - count / 5) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        idx = (($urandom_range(0, 5) == 0 && area < CELLS) || area == 0)
              ? $urandom_range(area, CELLS - 1) : $urandom_range(0, area - 1);
        send_op(OP_LOAD, idx, cell_rand(), cell_rand());
      end else if (pick < 82) begin
        if (area < CELLS && (loaded_upto == 0 || area == 0 || $urandom_range(0, 4) == 0))
          idx = $urandom_range(area, CELLS - 1);
        else
          idx = $urandom_range(0, ((loaded_upto < area) ? loaded_upto : area) - 1);
        send_op(OP_READ, idx, $urandom, $urandom);
      end else if (pick < 92) begin
        if ((n < 3 || (n <= 8 && loaded_upto >= area)) && (n < 3 || steps_r <= 8))
          send_op(OP_RUN, $urandom_range(0, CELLS - 1), $urandom, $urandom);
      end else begin
        send_op(OP_NONE, $urandom_range(0, CELLS - 1), $urandom, $urandom);
      end
    end
    drain();
    calm = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    loaded_upto = 0;
    side_r = RST_SIDE;
    steps_r = RST_STEPS;
    dt_r = RST_DT;
    axx_r = RST_AXX;
    ayy_r = RST_AYY;
    react_r = RST_REACT;
    for (int k = 0; k < CELLS; k++) begin
      grid_cur[k] = '0;
      grid_nxt[k] = '0;
      grid_src[k] = '0;
      loaded[k] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: side 10
    plan.insert(plan.size(), row(OP_LOAD, 0, 32'h7FFFFFFF, 32'h80000000, 1, 0, 0, 0));
    plan.insert(plan.size(), row(OP_READ, 0, 0, 0, 1, 32'h7FFFFFFF, 0, 0));
    plan.insert(plan.size(), row(OP_LOAD, 99, 32'h80000000, 32'h7FFFFFFF, 1, 0, 0, 0));
    plan.insert(plan.size(), row(OP_READ, 99, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'h80000000, 0, 0));
    plan.insert(plan.size(), row(OP_READ, 100, 0, 0, 1, 0, 0, 1));
    plan.insert(plan.size(), row(OP_READ, 4095, 0, 0, 1, 0, 0, 1));
    plan.insert(plan.size(), row(OP_LOAD, 100, 32'h12345678, 0, 1, 0, 0, 1));
    plan.insert(plan.size(), row(OP_LOAD, 4095, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 0, 1));
    plan.insert(plan.size(), row(OP_NONE, 4095, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 0, 0));
    plan.insert(plan.size(), row(OP_NONE, 5, 0, 0, 1, 0, 0, 0));
    plan.insert(plan.size(), row(OP_LOAD, 55, 32'h00010000, 32'h00008000, 1, 0, 0, 0));
    plan.insert(plan.size(), row(OP_LOAD, 44, 32'hFFFF0000, 32'h00000000, 1, 0, 0, 0));
    plan.insert(plan.size(), row(OP_READ, 55, 0, 0, 1, 32'h00010000, 0, 0));
    foreach (plan[r]) send_beat(plan[r].beat, plan[r].typed, plan[r].res);
    for (int k = 0; k < 100; k++)
      if (!loaded[k]) send_op(OP_LOAD, k, cell_rand(), cell_rand());
    send_row(row(OP_RUN, 0, 0, 0, 1, 0, 100, 0));
    send_op(OP_READ, 55, 0, 0);
    send_op(OP_READ, 44, 0, 0);
    send_op(OP_READ, 0, 0, 0);
    drain();

    set_regs(3, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    random_phase(200, 1, 0);
    set_regs(2, 65535, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    random_phase(150, 0, 1);
    set_regs(0, 5, 13107, 65536, 65536, 0);
    random_phase(100, 0, 0);
    set_regs(4, 3, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    random_phase(200, 0, 0);
    set_regs(127, 1, $urandom, $urandom, $urandom, $urandom);
    random_phase(150, 0, 0);
    set_regs(5, 4, $urandom_range(0, 1 << 14), $urandom_range(0, 1 << 17),
             $urandom_range(0, 1 << 17), 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16)));
    random_phase(250, 1, 1);
    set_regs(8, 2, $urandom_range(0, 1 << 12), $urandom, $urandom, $urandom);
    random_phase(200, 0, 0);
    set_regs(6, 8, $urandom_range(0, 1 << 13), 65536, 32'h00008000, 0);
    random_phase(200, 0, 0);
    set_regs(3, 6, $urandom, $urandom, $urandom, $urandom);
    random_phase(250, 0, 0);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
